@@ rtl/c_subset_lexer_macros.svh @@
// assertion helpers shared by the lexer files
`ifndef C_SUBSET_LEXER_MACROS_SVH
`define C_SUBSET_LEXER_MACROS_SVH

// same-cycle implication, checked out of reset
`define CLX_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("clx check failed");

// next-cycle implication, checked out of reset
`define CLX_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("clx check failed");

`endif

@@ rtl/clx_pkg.sv @@
`timescale 1ns / 1ps
package clx_pkg;

  localparam int OFFSET_BITS = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int MAX_RES     = 3;
  localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

  typedef logic [OFFSET_BITS-1:0] pos_t;

  // token kinds
  localparam logic [2:0] TK_NUMBER = 3'd0;
  localparam logic [2:0] TK_STREND = 3'd1;
  localparam logic [2:0] TK_NAME   = 3'd2;
  localparam logic [2:0] TK_KEYWD  = 3'd3;
  localparam logic [2:0] TK_SYM    = 3'd4;
  localparam logic [2:0] TK_END    = 3'd5;
  localparam logic [2:0] TK_STRBYT = 3'd6;
  localparam logic [2:0] TK_ERROR  = 3'd7;

  // error codes
  localparam logic [1:0] ERR_STRING  = 2'd1;
  localparam logic [1:0] ERR_COMMENT = 2'd2;
  localparam logic [1:0] ERR_BYTE    = 2'd3;

  typedef enum logic [3:0] {
    M_IDLE, M_NUMBER, M_IDENT, M_PUNCT, M_SLASH, M_LINE,
    M_BLOCK, M_STAR, M_STRING, M_ESC, M_ERROR
  } lex_mode_t;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       is_final;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [15:0] start_offset;
    logic [15:0] token_length;
    logic [30:0] number_value;
    logic        value_saturated;
    logic [2:0]  keyword_index;
    logic [7:0]  char_first;
    logic [7:0]  char_second;
    logic [1:0]  error_code;
    logic        final_result;
  } out_item_t;

  // all records caused by one byte
  typedef struct packed {
    out_item_t [MAX_RES-1:0] res;
    logic [1:0]              cnt;
  } bundle_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return ((c >= 8'h21) && (c <= 8'h2F)) || ((c >= 8'h3A) && (c <= 8'h40)) ||
           ((c >= 8'h5B) && (c <= 8'h60)) || ((c >= 8'h7B) && (c <= 8'h7E));
  endfunction

  function automatic logic [2:0] kw_len(input logic [2:0] k);
    logic [2:0] l;
    unique case (k)
      3'd0: l = 3'd6;
      3'd1: l = 3'd2;
      3'd2: l = 3'd4;
      3'd3: l = 3'd5;
      3'd4: l = 3'd3;
      3'd5: l = 3'd3;
      3'd6: l = 3'd4;
      default: l = 3'd6;
    endcase
    return l;
  endfunction

  // keyword text, right aligned, first char highest
  function automatic logic [47:0] kw_word(input logic [2:0] k);
    logic [47:0] w;
    unique case (k)
      3'd0: w = "return";
      3'd1: w = "if";
      3'd2: w = "else";
      3'd3: w = "while";
      3'd4: w = "for";
      3'd5: w = "int";
      3'd6: w = "char";
      default: w = "sizeof";
    endcase
    return w;
  endfunction

  // drop keywords that do not have byte c at index i
  function automatic logic [7:0] narrow(input logic [7:0] cand, input pos_t i,
                                        input logic [7:0] c);
    logic [7:0]  r;
    logic [47:0] w;
    logic [2:0]  sel;
    r = cand;
    for (int k = 0; k < 8; k++) begin
      w   = kw_word(3'(k));
      sel = 3'(kw_len(3'(k)) - 3'd1 - i[2:0]);
      if ((i >= pos_t'(kw_len(3'(k)))) || (w[8*sel +: 8] != c)) r[k] = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [7:0] decode_escape(input logic [7:0] c);
    logic [7:0] r;
    unique case (c)
      8'h6E:   r = 8'd10;
      8'h74:   r = 8'd9;
      8'h72:   r = 8'd13;
      8'h30:   r = 8'd0;
      default: r = c;
    endcase
    return r;
  endfunction

  function automatic out_item_t mk_rec(input logic [2:0] kind, input pos_t start,
                                       input pos_t len);
    out_item_t r;
    r = '0;
    r.token_kind   = kind;
    r.start_offset = 16'(start);
    r.token_length = 16'(len);
    return r;
  endfunction

  function automatic out_item_t mk_punct(input logic [7:0] a, input logic [7:0] b,
                                         input pos_t start);
    out_item_t r;
    r = mk_rec(TK_SYM, start, (b != 8'd0) ? pos_t'(2) : pos_t'(1));
    r.char_first  = a;
    r.char_second = b;
    return r;
  endfunction

  function automatic out_item_t mk_error(input logic [1:0] code, input pos_t start);
    out_item_t r;
    r = mk_rec(TK_ERROR, start, '0);
    r.error_code = code;
    return r;
  endfunction

  function automatic out_item_t mk_number(input pos_t start, input pos_t len,
                                          input logic [30:0] v, input logic sat);
    out_item_t r;
    r = mk_rec(TK_NUMBER, start, len);
    r.number_value    = v;
    r.value_saturated = sat;
    return r;
  endfunction

  function automatic out_item_t mk_ident(input pos_t start, input pos_t len,
                                         input logic [7:0] cand);
    out_item_t r;
    r = mk_rec(TK_NAME, start, len);
    // lowest matching keyword wins
    for (int k = 7; k >= 0; k--) begin
      if (cand[k] && (len == pos_t'(kw_len(3'(k))))) begin
        r.token_kind    = TK_KEYWD;
        r.keyword_index = 3'(k);
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/c_subset_lexer.sv @@
`timescale 1ns / 1ps
// channel  direction  payload     handshake
// in_      input      in_item_t   in_valid / in_ready
// out_     output     out_item_t  out_valid / out_ready
//
// one source byte is taken per cycle while the four-entry record queue has room
// each byte yields up to three records; the back end sends one record a cycle,
// unless out_ stalls, so multi-record bytes throttle input once the queue fills
// a byte's first record is written to the queue, then loaded into the back end
// bundle register before it is valid on out_; rst_n is synchronous and returns
// the lexer to offset zero with an empty queue; out_ stalls never reach the lexer state until the queue is full
module c_subset_lexer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  clx_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output clx_pkg::out_item_t out_data
);
  import clx_pkg::*;

  logic    take, push, q_full, q_valid, q_pop;
  bundle_t push_data, q_data;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  // lexer state machine
  clx_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .in_item (in_data),
    .push    (push),
    .bundle  (push_data)
  );

  // record queue
  clx_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (push),
    .wr_data   (push_data),
    .rd_en     (q_pop),
    .rd_data   (q_data),
    .full      (q_full),
    .not_empty (q_valid)
  );

  // record serializer
  clx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ rtl/clx_front.sv @@
`timescale 1ns / 1ps
module clx_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  clx_pkg::in_item_t in_item,
  output logic              push,
  output clx_pkg::bundle_t  bundle
);
  import clx_pkg::*;

  lex_mode_t   mode_r, mode_nxt;
  pos_t        pos_r, pos_nxt, begin_r, begin_nxt;
  logic [30:0] acc_r, acc_nxt;
  logic        clamp_r, clamp_nxt;
  logic [7:0]  cand_r, cand_nxt, held_r, held_nxt;
  logic [15:0] dcnt_r, dcnt_nxt;

  logic [7:0]  c;
  logic        fin, fresh;
  logic [1:0]  n;
  logic [34:0] prod;
  bundle_t     bnd;

  assign c   = in_item.source_byte;
  assign fin = in_item.is_final;

  // lexer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      pos_r   <= '0;
      begin_r <= '0;
      acc_r   <= '0;
      clamp_r <= 1'b0;
      cand_r  <= 8'hFF;
      held_r  <= '0;
      dcnt_r  <= '0;
    end else begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      begin_r <= begin_nxt;
      acc_r   <= acc_nxt;
      clamp_r <= clamp_nxt;
      cand_r  <= cand_nxt;
      held_r  <= held_nxt;
      dcnt_r  <= dcnt_nxt;
    end
  end

  // per-byte decision, then end-of-text flush
  always_comb begin
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    begin_nxt = begin_r;
    acc_nxt   = acc_r;
    clamp_nxt = clamp_r;
    cand_nxt  = cand_r;
    held_nxt  = held_r;
    dcnt_nxt  = dcnt_r;
    bnd       = '0;
    n         = '0;
    fresh     = 1'b0;
    prod      = ({4'd0, acc_r} << 3) + ({4'd0, acc_r} << 1) + 35'(c - 8'h30);
    if (take) begin
      if (c != 8'd0) begin
        unique case (mode_r)
          M_NUMBER: begin
            if (is_digit(c)) begin
              if (prod > 35'(NUM_MAX)) begin
                acc_nxt   = NUM_MAX;
                clamp_nxt = 1'b1;
              end else begin
                acc_nxt = prod[30:0];
              end
            end else begin
              bnd.res[n] = mk_number(begin_r, pos_r - begin_r, acc_r, clamp_r);
              n = n + 2'd1;
              fresh = 1'b1;
            end
          end
          M_IDENT: begin
            if (is_alpha(c) || is_digit(c) || (c == 8'h5F)) begin
              cand_nxt = narrow(cand_r, pos_r - begin_r, c);
            end else begin
              bnd.res[n] = mk_ident(begin_r, pos_r - begin_r, cand_r);
              n = n + 2'd1;
              fresh = 1'b1;
            end
          end
          M_PUNCT: begin
            if (c == 8'h3D) begin
              bnd.res[n] = mk_punct(held_r, 8'h3D, begin_r);
              n = n + 2'd1;
              mode_nxt = M_IDLE;
            end else begin
              bnd.res[n] = mk_punct(held_r, 8'd0, begin_r);
              n = n + 2'd1;
              fresh = 1'b1;
            end
          end
          M_SLASH: begin
            if (c == 8'h2F) begin
              mode_nxt = M_LINE;
            end else if (c == 8'h2A) begin
              mode_nxt = M_BLOCK;
            end else begin
              bnd.res[n] = mk_punct(8'h2F, 8'd0, begin_r);
              n = n + 2'd1;
              fresh = 1'b1;
            end
          end
          M_LINE: begin
            if (c == 8'h0A) mode_nxt = M_IDLE;
          end
          M_BLOCK: begin
            if (c == 8'h2A) mode_nxt = M_STAR;
          end
          M_STAR: begin
            if (c == 8'h2F) mode_nxt = M_IDLE;
            else if (c != 8'h2A) mode_nxt = M_BLOCK;
          end
          M_STRING: begin
            if (c == 8'h22) begin
              bnd.res[n] = mk_rec(TK_STREND, begin_r, pos_r + pos_t'(1) - begin_r);
              n = n + 2'd1;
              mode_nxt = M_IDLE;
            end else if (c == 8'h5C) begin
              mode_nxt = M_ESC;
            end else if (c == 8'h0A) begin
              bnd.res[n] = mk_error(ERR_STRING, begin_r);
              n = n + 2'd1;
              mode_nxt = M_ERROR;
            end else begin
              dcnt_nxt = dcnt_r + 16'd1;
              bnd.res[n] = mk_rec(TK_STRBYT, pos_r, pos_t'(dcnt_nxt));
              bnd.res[n].char_first = c;
              n = n + 2'd1;
            end
          end
          M_ESC: begin
            dcnt_nxt = dcnt_r + 16'd1;
            bnd.res[n] = mk_rec(TK_STRBYT, pos_r - pos_t'(1), pos_t'(dcnt_nxt));
            bnd.res[n].char_first = decode_escape(c);
            n = n + 2'd1;
            mode_nxt = M_STRING;
          end
          M_ERROR: begin
            mode_nxt = M_ERROR;
          end
          default: begin
            fresh = 1'b1;
          end
        endcase

        // start of a new token
        if (fresh) begin
          mode_nxt  = M_IDLE;
          begin_nxt = pos_r;
          priority if (is_space(c)) begin
            mode_nxt = M_IDLE;
          end else if (is_digit(c)) begin
            mode_nxt  = M_NUMBER;
            acc_nxt   = 31'(c - 8'h30);
            clamp_nxt = 1'b0;
          end else if (is_alpha(c) || (c == 8'h5F)) begin
            mode_nxt = M_IDENT;
            cand_nxt = narrow(8'hFF, '0, c);
          end else if (c == 8'h22) begin
            mode_nxt = M_STRING;
            dcnt_nxt = '0;
          end else if (c == 8'h2F) begin
            mode_nxt = M_SLASH;
            held_nxt = c;
          end else if ((c == 8'h3D) || (c == 8'h21) || (c == 8'h3C) || (c == 8'h3E)) begin
            mode_nxt = M_PUNCT;
            held_nxt = c;
          end else if (is_punct(c)) begin
            bnd.res[n] = mk_punct(c, 8'd0, pos_r);
            n = n + 2'd1;
          end else begin
            bnd.res[n] = mk_error(ERR_BYTE, pos_r);
            n = n + 2'd1;
            mode_nxt = M_ERROR;
          end
        end
        pos_nxt = pos_r + pos_t'(1);
      end

      // end of text: flush pending token, emit end, back to reset
      if ((c == 8'd0) || fin) begin
        unique case (mode_nxt)
          M_NUMBER: begin
            bnd.res[n] = mk_number(begin_nxt, pos_nxt - begin_nxt, acc_nxt, clamp_nxt);
            n = n + 2'd1;
          end
          M_IDENT: begin
            bnd.res[n] = mk_ident(begin_nxt, pos_nxt - begin_nxt, cand_nxt);
            n = n + 2'd1;
          end
          M_PUNCT, M_SLASH: begin
            bnd.res[n] = mk_punct(held_nxt, 8'd0, begin_nxt);
            n = n + 2'd1;
          end
          M_STRING, M_ESC: begin
            bnd.res[n] = mk_error(ERR_STRING, begin_nxt);
            n = n + 2'd1;
          end
          M_BLOCK, M_STAR: begin
            bnd.res[n] = mk_error(ERR_COMMENT, begin_nxt);
            n = n + 2'd1;
          end
          default: begin
            n = n;
          end
        endcase
        bnd.res[n] = mk_rec(TK_END, pos_nxt, '0);
        bnd.res[n].final_result = 1'b1;
        n = n + 2'd1;
        mode_nxt  = M_IDLE;
        pos_nxt   = '0;
        begin_nxt = '0;
        acc_nxt   = '0;
        clamp_nxt = 1'b0;
        cand_nxt  = 8'hFF;
        held_nxt  = '0;
        dcnt_nxt  = '0;
      end
    end
    bnd.cnt = n;
  end

  assign push   = take && (n != 2'd0);
  assign bundle = bnd;

endmodule

@@ rtl/clx_fifo.sv @@
`timescale 1ns / 1ps
`include "c_subset_lexer_macros.svh"
module clx_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  clx_pkg::bundle_t wr_data,
  input  logic             rd_en,
  output clx_pkg::bundle_t rd_data,
  output logic             full,
  output logic             not_empty
);
  import clx_pkg::*;

  bundle_t           slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QPTR_W:0]   count_r;

  assign full      = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign rd_data   = slot_r[rptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) slot_r[wptr_r] <= wr_data;
  end

  // pointers and fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (wr_en) wptr_r <= wptr_r + 1'b1;
      if (rd_en) rptr_r <= rptr_r + 1'b1;
      count_r <= count_r + (QPTR_W+1)'(wr_en) - (QPTR_W+1)'(rd_en);
    end
  end

  `CLX_ASSERT_NOW(a_no_overflow, wr_en && !rd_en, !full)
  `CLX_ASSERT_NOW(a_no_underflow, rd_en, not_empty)
  `CLX_ASSERT_NOW(a_no_empty_bundle, wr_en, wr_data.cnt != 2'd0)

endmodule

@@ rtl/clx_back.sv @@
`timescale 1ns / 1ps
`include "c_subset_lexer_macros.svh"
module clx_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  clx_pkg::bundle_t   q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output clx_pkg::out_item_t out_data
);
  import clx_pkg::*;

  bundle_t    cur_r;
  logic       vld_r;
  logic [1:0] idx_r;
  logic       last;

  assign last      = (idx_r + 2'd1 == cur_r.cnt);
  assign q_pop     = q_valid && (!vld_r || (out_ready && last));
  assign out_valid = vld_r;
  assign out_data  = cur_r.res[idx_r];

  // hold one bundle and step through its records
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else if (q_pop) begin
      vld_r <= 1'b1;
      idx_r <= '0;
    end else if (vld_r && out_ready) begin
      if (last) vld_r <= 1'b0;
      else idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_data;
  end

  `CLX_ASSERT_NOW(a_idx_in_range, vld_r, idx_r < cur_r.cnt)
  `CLX_ASSERT_NEXT(a_stall_holds, vld_r && !out_ready, vld_r && $stable(idx_r))
  `CLX_ASSERT_NEXT(a_data_holds, vld_r && !out_ready, $stable(out_data))

endmodule

@@ test/c_subset_lexer_checker.sv @@
`timescale 1ns / 1ps
module c_subset_lexer_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  clx_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  clx_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 tokens_pending
);
  import clx_pkg::*;

  // lexer state mirror
  lex_mode_t   mode;
  logic [15:0] pos;
  logic [15:0] tok_start;
  logic [30:0] num_acc;
  logic        num_sat;
  logic [7:0]  kw_cand;
  logic [7:0]  held;
  logic [15:0] str_count;

  out_item_t token_q[$];

  assign tokens_pending = token_q.size();

  function automatic logic [47:0] kw_text(input int k);
    case (k)
      0: return "return";
      1: return "if";
      2: return "else";
      3: return "while";
      4: return "for";
      5: return "int";
      6: return "char";
      default: return "sizeof";
    endcase
  endfunction

  function automatic int kw_size(input int k);
    int sizes[8] = '{6, 2, 4, 5, 3, 3, 4, 6};
    return sizes[k];
  endfunction

  function automatic logic c_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic c_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic c_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic c_punct(input logic [7:0] c);
    return (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
           (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
  endfunction

  task automatic push_tok(input logic [2:0] kind, input logic [15:0] st,
                          input logic [15:0] len, output out_item_t r);
    r = '0;
    r.token_kind = kind;
    r.start_offset = st;
    r.token_length = len;
  endtask

  task automatic emit_punct(input logic [7:0] a, input logic [7:0] b,
                            input logic [15:0] st);
    out_item_t r;
    push_tok(TK_SYM, st, (b != 0) ? 16'd2 : 16'd1, r);
    r.char_first = a;
    r.char_second = b;
    token_q.push_back(r);
  endtask

  task automatic emit_error(input logic [1:0] code, input logic [15:0] st);
    out_item_t r;
    push_tok(TK_ERROR, st, 16'd0, r);
    r.error_code = code;
    token_q.push_back(r);
    mode = M_ERROR;
  endtask

  task automatic emit_str_byte(input logic [7:0] b, input logic [15:0] st);
    out_item_t r;
    str_count = str_count + 16'd1;
    push_tok(TK_STRBYT, st, str_count, r);
    r.char_first = b;
    token_q.push_back(r);
  endtask

  task automatic emit_number();
    out_item_t r;
    push_tok(TK_NUMBER, tok_start, pos - tok_start, r);
    r.number_value = num_acc;
    r.value_saturated = num_sat;
    token_q.push_back(r);
  endtask

  task automatic emit_word();
    out_item_t   r;
    logic [15:0] len;
    len = pos - tok_start;
    push_tok(TK_NAME, tok_start, len, r);
    for (int k = 7; k >= 0; k--)
      if (kw_cand[k] && len == 16'(kw_size(k))) begin
        r.token_kind = TK_KEYWD;
        r.keyword_index = 3'(k);
      end
    token_q.push_back(r);
  endtask

  task automatic drop_keywords(input logic [7:0] c);
    logic [15:0] i;
    logic [47:0] w;
    i = pos - tok_start;
    for (int k = 0; k < 8; k++) begin
      w = kw_text(k);
      if (i >= 16'(kw_size(k))) kw_cand[k] = 1'b0;
      else if (w[8*(kw_size(k) - 1 - int'(i)) +: 8] != c) kw_cand[k] = 1'b0;
    end
  endtask

  task automatic clear_state();
    mode = M_IDLE;
    pos = '0;
    tok_start = '0;
    num_acc = '0;
    num_sat = 1'b0;
    kw_cand = 8'hFF;
    held = '0;
    str_count = '0;
  endtask

  function automatic logic [7:0] unescape(input logic [7:0] c);
    case (c)
      "n": return 8'd10;
      "t": return 8'd9;
      "r": return 8'd13;
      "0": return 8'd0;
      default: return c;
    endcase
  endfunction

  // lex one nonzero byte
  task automatic lex_byte(input logic [7:0] c);
    logic [34:0] v;
    logic        fresh;
    fresh = 1'b1;
    case (mode)
      M_NUMBER: begin
        if (c_digit(c)) begin
          v = 35'(num_acc) * 35'd10 + 35'(c - "0");
          if (v > 35'(NUM_MAX)) begin
            v = 35'(NUM_MAX);
            num_sat = 1'b1;
          end
          num_acc = v[30:0];
          fresh = 1'b0;
        end else emit_number();
      end
      M_IDENT: begin
        if (c_alpha(c) || c_digit(c) || c == "_") begin
          drop_keywords(c);
          fresh = 1'b0;
        end else emit_word();
      end
      M_PUNCT: begin
        if (c == "=") begin
          emit_punct(held, "=", tok_start);
          mode = M_IDLE;
          fresh = 1'b0;
        end else emit_punct(held, 8'd0, tok_start);
      end
      M_SLASH: begin
        if (c == "/") begin
          mode = M_LINE;
          fresh = 1'b0;
        end else if (c == "*") begin
          mode = M_BLOCK;
          fresh = 1'b0;
        end else emit_punct("/", 8'd0, tok_start);
      end
      M_LINE: begin
        if (c == 8'd10) mode = M_IDLE;
        fresh = 1'b0;
      end
      M_BLOCK: begin
        if (c == "*") mode = M_STAR;
        fresh = 1'b0;
      end
      M_STAR: begin
        if (c == "/") mode = M_IDLE;
        else if (c != "*") mode = M_BLOCK;
        fresh = 1'b0;
      end
      M_STRING: begin
        out_item_t r;
        if (c == "\"") begin
          push_tok(TK_STREND, tok_start, pos + 16'd1 - tok_start, r);
          token_q.push_back(r);
          mode = M_IDLE;
        end else if (c == "\\") mode = M_ESC;
        else if (c == 8'd10) emit_error(ERR_STRING, tok_start);
        else emit_str_byte(c, pos);
        fresh = 1'b0;
      end
      M_ESC: begin
        emit_str_byte(unescape(c), pos - 16'd1);
        mode = M_STRING;
        fresh = 1'b0;
      end
      M_ERROR: fresh = 1'b0;
      default: ;
    endcase
    if (fresh) begin
      mode = M_IDLE;
      tok_start = pos;
      if (c_space(c)) ;
      else if (c_digit(c)) begin
        mode = M_NUMBER;
        num_acc = 31'(c - "0");
        num_sat = 1'b0;
      end else if (c_alpha(c) || c == "_") begin
        mode = M_IDENT;
        kw_cand = 8'hFF;
        drop_keywords(c);
      end else if (c == "\"") begin
        mode = M_STRING;
        str_count = '0;
      end else if (c == "/") begin
        mode = M_SLASH;
        held = c;
      end else if (c == "=" || c == "!" || c == "<" || c == ">") begin
        mode = M_PUNCT;
        held = c;
      end else if (c_punct(c)) emit_punct(c, 8'd0, pos);
      else emit_error(ERR_BYTE, pos);
    end
  endtask

  // flush the open token and close the text
  task automatic end_text();
    out_item_t r;
    case (mode)
      M_NUMBER: emit_number();
      M_IDENT: emit_word();
      M_PUNCT, M_SLASH: emit_punct(held, 8'd0, tok_start);
      M_STRING, M_ESC: emit_error(ERR_STRING, tok_start);
      M_BLOCK, M_STAR: emit_error(ERR_COMMENT, tok_start);
      default: ;
    endcase
    push_tok(TK_END, pos, 16'd0, r);
    r.final_result = 1'b1;
    token_q.push_back(r);
    clear_state();
  endtask

  task automatic cmp(input string name, input longint e, input longint a);
    if (e != a) begin
      $error("%s mismatch: expected %0d, got %0d", name, e, a);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
      token_q.delete();
      fail_count = 0;
    end else begin
      // predict on each accepted request
      if (in_valid && in_ready) begin
        if (in_data.source_byte != 8'd0) begin
          lex_byte(in_data.source_byte);
          pos = pos + 16'd1;
        end
        if (in_data.source_byte == 8'd0 || in_data.is_final) end_text();
      end
      // compare each accepted token
      if (out_valid && out_ready) begin
        if (token_q.size() == 0) begin
          $error("unexpected token kind %0d at offset %0d",
                 out_data.token_kind, out_data.start_offset);
          fail_count++;
        end else begin
          out_item_t e;
          e = token_q.pop_front();
          cmp("token_kind", e.token_kind, out_data.token_kind);
          cmp("start_offset", e.start_offset, out_data.start_offset);
          cmp("token_length", e.token_length, out_data.token_length);
          cmp("number_value", e.number_value, out_data.number_value);
          cmp("value_saturated", e.value_saturated, out_data.value_saturated);
          cmp("keyword_index", e.keyword_index, out_data.keyword_index);
          cmp("char_first", e.char_first, out_data.char_first);
          cmp("char_second", e.char_second, out_data.char_second);
          cmp("error_code", e.error_code, out_data.error_code);
          cmp("final_result", e.final_result, out_data.final_result);
        end
      end
    end
  end
endmodule

@@ test/c_subset_lexer_tb.sv @@
`timescale 1ns / 1ps
module c_subset_lexer_tb;
  import clx_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  int        fail_count;
  int        tokens_pending;
  int        hold_cycles;
  logic      stall_on;

  logic [7:0] text_q[$];
  logic       last_q[$];

  c_subset_lexer u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  c_subset_lexer_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .tokens_pending(tokens_pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // queue text bytes; last flags the final byte
  task automatic put_text(input string s, input logic last);
    for (int i = 0; i < s.len(); i++) begin
      text_q.push_back(s[i]);
      last_q.push_back(last && i == s.len() - 1);
    end
  endtask

  task automatic put_byte(input logic [7:0] b, input logic last);
    text_q.push_back(b);
    last_q.push_back(last);
  endtask

  // random fragment, sometimes with a stray byte
  task automatic put_fragment();
    string words[12] = '{"return", "if", "else", "while", "for", "int", "char",
                         "sizeof", "retur", "whilex", "_a9", "Foo"};
    string ops[10] = '{"==", "!=", "<=", ">=", "=", "<", "!", "(", ";", "/"};
    int n;
    case ($urandom_range(0, 9))
      0, 1: put_text(words[$urandom_range(0, 11)], 1'b0);
      2: begin
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) put_byte(8'($urandom_range("0", "9")), 1'b0);
      end
      3, 4: put_text(ops[$urandom_range(0, 9)], 1'b0);
      5: begin
        put_byte("\"", 1'b0);
        n = $urandom_range(0, 5);
        for (int i = 0; i < n; i++)
          if ($urandom_range(0, 3) == 0) begin
            put_byte("\\", 1'b0);
            put_byte(8'($urandom_range(8'h20, 8'hFF)), 1'b0);
          end else put_byte(8'($urandom_range(8'h20, 8'hFF)) | 8'h01, 1'b0);
        put_byte("\"", 1'b0);
      end
      6: put_text("/* x*y **/", 1'b0);
      7: put_text("// c\n", 1'b0);
      8: put_byte(8'($urandom_range(9, 13)), 1'b0);
      default: put_byte(8'($urandom_range(1, 255)), 1'b0);
    endcase
    put_byte(" ", 1'b0);
  endtask

  // receiver: random stalls plus one long hold-off
  initial begin
    out_ready = 1'b0;
    stall_on = 1'b0;
    hold_cycles = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_on) begin
        out_ready <= 1'b0;
        repeat (60) @(negedge clk);
        stall_on = 1'b0;
        out_ready <= 1'b1;
      end else if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        hold_cycles = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
      end
    end
  end

  initial begin
    #3000000;
    $display("c_subset_lexer regression: fail");
    $finish;
  end

  initial begin
    int gap;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed texts covering each special case
    put_text("return x1=0x;", 1'b0);
    put_byte(8'd0, 1'b0);
    put_text("99999999999 a!=b<=c>=d==e/f", 1'b1);
    put_text("\"a\\n\\t\\r\\0\\\\\\\"\\'\\q\"", 1'b1);
    put_text("/* */ // z\nsizeof", 1'b1);
    put_text("\"abc\ndef", 1'b1);
    put_text("/* open", 1'b1);
    put_byte(8'h80, 1'b0);
    put_byte(8'h7F, 1'b1);
    put_text("\"tail", 1'b1);
    put_byte(8'hFF, 1'b0);
    put_byte(8'd0, 1'b1);

    // random texts
    while (text_q.size() < 470) begin
      repeat ($urandom_range(1, 8)) put_fragment();
      if ($urandom_range(0, 1)) put_byte(8'd0, 1'b0);
      else put_byte(8'($urandom_range(1, 255)), 1'b1);
    end

    for (int i = 0; text_q.size() > 0; i++) begin
      if (i == 150) stall_on = 1'b1;
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 13) : 0;
      // idle between requests; once drain every expected result first
      if (gap > 0 || i == 300) begin
        in_valid <= 1'b0;
        if (i == 300) begin
          @(negedge clk);
          while (tokens_pending != 0) @(negedge clk);
        end
        repeat (gap) @(negedge clk);
      end
      in_data <= '{source_byte: text_q.pop_front(), is_final: last_q.pop_front()};
      in_valid <= 1'b1;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      @(negedge clk);
    end
    in_valid <= 1'b0;

    fork
      while (tokens_pending != 0) @(negedge clk);
      begin
        #200000;
        $display("c_subset_lexer regression: fail");
        $finish;
      end
    join_any
    disable fork;
    repeat (20) @(negedge clk);
    if (fail_count == 0) $display("c_subset_lexer regression: pass");
    else $display("c_subset_lexer regression: fail");
    $finish;
  end
endmodule
